### sv/bfe_pkg.sv
package bfe_pkg;

    localparam int KEY_W      = 32;
    localparam int CFG_W      = 11;
    localparam int DATA_W     = 64;
    localparam int BIT_SEL_W  = 6;
    localparam int DVD_W      = KEY_W - BIT_SEL_W;
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = KEY_W / DIGIT_W;

    localparam logic [KEY_W-1:0] MIX_MULT  = 32'h045d_9f3b;
    localparam logic [CFG_W-1:0] WIU_RESET = 11'd1024;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HASH = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_READ = 4'b1000
    } state_t;

    function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [KEY_W-1:0] digit_product(input logic [DIGIT_W-1:0] d);
        return MIX_MULT * {{(KEY_W-DIGIT_W){1'b0}}, d};
    endfunction

endpackage

### sv/bfe_hash.sv
module bfe_hash
    import bfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             valid,
    output logic [KEY_W-1:0] hash
);

    // Each multiplication takes one nibble of the operand per cycle, most
    // significant first, and accumulates by Horner's rule modulo 2^32.
    localparam int DCNT_W = $clog2(MUL_DIGITS);

    logic              running_reg, running_next;
    logic              pass_reg, pass_next;
    logic              valid_reg, valid_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]  opnd_reg, opnd_next;
    logic [KEY_W-1:0]  acc_reg, acc_next;
    logic [KEY_W-1:0]  hash_reg, hash_next;
    logic [KEY_W-1:0]  acc_sum;

    assign acc_sum = {acc_reg[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                   + digit_product(opnd_reg[KEY_W-1 -: DIGIT_W]);

    always_comb
    begin
        running_next = running_reg;
        pass_next    = pass_reg;
        valid_next   = 1'b0;
        cnt_next     = cnt_reg;
        opnd_next    = opnd_reg;
        acc_next     = acc_reg;
        hash_next    = hash_reg;
        if (start)
        begin
            running_next = 1'b1;
            pass_next    = 1'b0;
            cnt_next     = '0;
            opnd_next    = mix_step(key);
            acc_next     = '0;
        end
        else if (running_reg)
        begin
            opnd_next = {opnd_reg[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            acc_next  = acc_sum;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(MUL_DIGITS - 1))
            begin
                cnt_next = '0;
                acc_next = '0;
                if (!pass_reg)
                begin
                    pass_next = 1'b1;
                    opnd_next = mix_step(acc_sum);
                end
                else
                begin
                    running_next = 1'b0;
                    valid_next   = 1'b1;
                    hash_next    = mix_step(acc_sum);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            pass_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            pass_reg    <= pass_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
        hash_reg <= hash_next;
    end

    assign valid = valid_reg;
    assign hash  = hash_reg;

endmodule

### sv/bfe_div.sv
module bfe_div
    import bfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             valid,
    output logic [CFG_W-1:0] remainder
);

    // Restoring division, one dividend bit per cycle; only the remainder is kept.
    localparam int SCNT_W = $clog2(DVD_W);

    logic              running_reg, running_next;
    logic              valid_reg, valid_next;
    logic [SCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CFG_W-1:0]  dsr_reg, dsr_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [CFG_W:0]    trial;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};

    always_comb
    begin
        running_next = running_reg;
        valid_next   = 1'b0;
        cnt_next     = cnt_reg;
        dvd_next     = dvd_reg;
        dsr_next     = dsr_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            dvd_next     = dividend;
            dsr_next     = divisor;
            rem_next     = '0;
        end
        else if (running_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (trial >= {1'b0, dsr_reg})
                rem_next = CFG_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = CFG_W'(trial);
            if (cnt_reg == SCNT_W'(DVD_W - 1))
            begin
                running_next = 1'b0;
                valid_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            valid_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign valid     = valid_reg;
    assign remainder = rem_reg;

endmodule

### sv/bfe_store.sv
module bfe_store
    import bfe_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              clearing
);

    // After reset every word is written with zero, one word per cycle.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_reg, clr_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;

    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == DEPTH - 1)
                clr_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_reg;

endmodule

### sv/bloom_filter_engine.sv
// Channel   Ports                                        Handshake
// input     opcode, key, word_index, merge_word          start & !busy
// result    hit, rejected                                done, one cycle
// config    cfg_wdata (words_in_use)                     cfg_we
//
// An insert or query runs the nibble-serial hash, the bit-serial remainder,
// then hand-over, store read and, for an insert only, write-back, before the
// next acceptance. A merge reads and writes back its word; a rejected merge
// or unused opcode gives its result without raising busy.
// After reset busy stays high while the store is cleared.
// Results cannot be stalled; done marks each one for exactly one cycle.
module bloom_filter_engine
    import bfe_pkg::*;
#(
    parameter int MAX_WORDS = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [KEY_W-1:0]  key,
    input  logic [9:0]        word_index,
    input  logic [DATA_W-1:0] merge_word,
    output logic              done,
    output logic              hit,
    output logic              rejected
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  wiu_reg;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic              rej_reg, rej_next;
    logic [1:0]        op_reg, op_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic [BIT_SEL_W-1:0] bit_reg, bit_next;
    logic [AW-1:0]     addr_reg, addr_next;

    logic [CFG_W-1:0]  active;
    logic              accept;
    logic              merge_ok;
    logic              hash_start, hash_valid;
    logic [KEY_W-1:0]  hash;
    logic              div_start, div_valid;
    logic [CFG_W-1:0]  rem;
    logic [31:0]       idx_ext, rem_ext;
    logic [AW-1:0]     idx_addr, rem_addr;
    logic              rd_en, wr_en, clearing;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data, wr_data, bit_mask;

    always_comb
    begin
        if (wiu_reg == '0)
            active = CFG_W'(1);
        else if (32'(wiu_reg) > MAX_WORDS)
            active = CFG_W'(MAX_WORDS);
        else
            active = wiu_reg;
    end

    assign busy     = (state_reg != ST_IDLE) || clearing;
    assign accept   = start && !busy;
    assign merge_ok = {1'b0, word_index} < active;
    assign idx_ext  = 32'(word_index);
    assign rem_ext  = 32'(rem);
    assign idx_addr = idx_ext[AW-1:0];
    assign rem_addr = rem_ext[AW-1:0];
    assign rd_addr  = (state_reg == ST_IDLE) ? idx_addr : rem_addr;
    assign bit_mask = {{(DATA_W-1){1'b0}}, 1'b1} << bit_reg;
    assign wr_data  = rd_data | ((op_reg == OP_MERGE) ? word_reg : bit_mask);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        hit_next   = 1'b0;
        rej_next   = 1'b0;
        op_next    = op_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        addr_next  = addr_reg;
        hash_start = 1'b0;
        div_start  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode;
                    word_next = merge_word;
                    case (opcode)
                        OP_INSERT, OP_QUERY:
                        begin
                            hash_start = 1'b1;
                            state_next = ST_HASH;
                        end
                        OP_MERGE:
                        begin
                            if (merge_ok)
                            begin
                                rd_en      = 1'b1;
                                addr_next  = idx_addr;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rej_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                if (hash_valid)
                begin
                    div_start  = 1'b1;
                    bit_next   = hash[BIT_SEL_W-1:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_valid)
                begin
                    rd_en      = 1'b1;
                    addr_next  = rem_addr;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                hit_next   = (op_reg == OP_QUERY) && rd_data[bit_reg];
                wr_en      = (op_reg != OP_QUERY);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wiu_reg   <= WIU_RESET;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            rej_reg   <= rej_next;
            if (cfg_we)
                wiu_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        word_reg <= word_next;
        bit_reg  <= bit_next;
        addr_reg <= addr_next;
    end

    bfe_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .valid (hash_valid),
        .hash  (hash)
    );

    bfe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (hash[KEY_W-1:BIT_SEL_W]),
        .divisor   (active),
        .valid     (div_valid),
        .remainder (rem)
    );

    bfe_store #(
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (addr_reg),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign rejected = rej_reg;

endmodule

### sv/bfe_checker.sv
module bfe_checker
    import bfe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] opcode,
    input logic       done,
    input logic       hit,
    input logic       rejected
);

    a_quiet_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!hit && !rejected))
        else $error("Result flags are set without a result strobe.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && rejected))
        else $error("A result is both a hit and rejected.");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("The engine is still busy while showing a result.");

    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_NONE) |=> (done && !hit && !rejected))
        else $error("An unused opcode did not give an empty result in the next cycle.");

    a_key_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_INSERT || opcode == OP_QUERY)) |=> (busy && !done))
        else $error("A key operation did not hold the engine busy.");

endmodule

bind bloom_filter_engine bfe_checker u_checker (.*);

### verif/tb_bloom_filter_engine.sv
module tb_bloom_filter_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import bfe_pkg::*;

    localparam int MAX_WORDS   = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam int POOL_DEPTH  = 64;

    typedef struct packed {
        logic hit;
        logic rejected;
    } lookup_result_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata  = '0;
    logic              start      = 1'b0;
    logic              busy;
    logic [1:0]        opcode     = OP_INSERT;
    logic [KEY_W-1:0]  key        = '0;
    logic [9:0]        word_index = '0;
    logic [DATA_W-1:0] merge_word = '0;
    logic              done;
    logic              hit;
    logic              rejected;

    logic [DATA_W-1:0] filter_mem [MAX_WORDS];
    logic [CFG_W-1:0]  words_cfg = WIU_RESET;
    lookup_result_t    pending_results [$];
    logic [KEY_W-1:0]  key_pool [$];
    int                mismatches  = 0;
    int                idle_cycles = 0;
    bit                sender_gaps = 1'b1;

    bloom_filter_engine #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .key        (key),
        .word_index (word_index),
        .merge_word (merge_word),
        .done       (done),
        .hit        (hit),
        .rejected   (rejected)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [KEY_W-1:0] fold16(input logic [KEY_W-1:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [KEY_W-1:0] key_hash(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = fold16(k);
        h = h * MIX_MULT;
        h = fold16(h);
        h = h * MIX_MULT;
        return fold16(h);
    endfunction

    function automatic int unsigned live_words();
        int unsigned n;
        n = words_cfg;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_WORDS)
        begin
            n = MAX_WORDS;
        end
        return n;
    endfunction

    function automatic int unsigned bit_pos(input logic [KEY_W-1:0] k);
        int unsigned h;
        h = key_hash(k);
        return h % (live_words() * 64);
    endfunction

    function automatic lookup_result_t apply_item(input logic [1:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [9:0] idx,
                                                 input logic [DATA_W-1:0] w);
        lookup_result_t res;
        int unsigned    pos;
        res = '0;
        case (op)
            OP_INSERT:
            begin
                pos = bit_pos(k);
                filter_mem[pos / 64][pos % 64] = 1'b1;
            end
            OP_QUERY:
            begin
                pos = bit_pos(k);
                res.hit = filter_mem[pos / 64][pos % 64];
            end
            OP_MERGE:
            begin
                if (idx < live_words())
                begin
                    filter_mem[idx] = filter_mem[idx] | w;
                end
                else
                begin
                    res.rejected = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                begin
                    report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
                end
                if (rejected !== want.rejected)
                begin
                    report_mismatch($sformatf("rejected %b, expected %b",
                                              rejected, want.rejected));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [9:0] idx, input logic [DATA_W-1:0] w);
        if (sender_gaps && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 40)
            begin
                @(posedge clk);
            end
        end
        start      <= 1'b1;
        opcode     <= op;
        key        <= k;
        word_index <= idx;
        merge_word <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_results.push_back(apply_item(op, k, idx, w));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_word_count(input logic [CFG_W-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        words_cfg = value;
    endtask

    task automatic test_basic_ops();
        send_item(OP_QUERY, 32'h0, 10'd0, '0);
        send_item(OP_INSERT, 32'h0, 10'd0, '0);
        send_item(OP_QUERY, 32'h0, 10'd0, '0);
        send_item(OP_INSERT, '1, '1, '1);
        send_item(OP_QUERY, '1, '1, '1);
        send_item(OP_NONE, '1, '1, '1);
        send_item(OP_MERGE, 32'h0, 10'd0, '1);
        send_item(OP_QUERY, 32'h0000_1234, 10'd0, '0);
        send_item(OP_MERGE, 32'h0, 10'd1023, '0);
    endtask

    task automatic test_word_count_edges();
        write_word_count(11'd1);
        send_item(OP_INSERT, 32'd5, 10'd0, '0);
        send_item(OP_QUERY, 32'd6, 10'd0, '0);
        send_item(OP_MERGE, 32'd0, 10'd0, '0);
        send_item(OP_MERGE, 32'd0, 10'd1, '1);
        send_item(OP_MERGE, 32'd0, 10'd1023, '1);
        write_word_count(11'd0);
        send_item(OP_MERGE, 32'd0, 10'd1, '1);
        send_item(OP_MERGE, 32'd0, 10'd0, '1);
        send_item(OP_QUERY, 32'd7, 10'd0, '0);
        write_word_count(11'd2047);
        send_item(OP_MERGE, 32'd0, 10'd1023, '1);
        send_item(OP_QUERY, '1, 10'd0, '0);
        write_word_count(11'd1025);
        send_item(OP_MERGE, 32'd0, 10'd1023, 64'd1);
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] wcount, input int n_items,
                                    input bit with_gaps);
        int               r;
        logic [1:0]       op;
        logic [KEY_W-1:0] k;
        logic [9:0]       idx;
        logic [DATA_W-1:0] w;
        write_word_count(wcount);
        sender_gaps = with_gaps;
        for (int i = 0; i < n_items; i++)
        begin
            r   = $urandom_range(99);
            k   = $urandom;
            idx = $urandom_range(1023);
            w   = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
            begin
                w = w & {$urandom, $urandom};
            end
            if (r < 35)
            begin
                op = OP_INSERT;
            end
            else if (r < 70)
            begin
                op = OP_QUERY;
                if (key_pool.size() != 0 && $urandom_range(99) < 60)
                begin
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                end
            end
            else if (r < 92)
            begin
                op = OP_MERGE;
                if ($urandom_range(1) == 0)
                begin
                    idx = $urandom_range(live_words() - 1);
                end
            end
            else
            begin
                op = OP_NONE;
            end
            if (op == OP_INSERT)
            begin
                key_pool.push_back(k);
                if (key_pool.size() > POOL_DEPTH)
                begin
                    void'(key_pool.pop_front());
                end
            end
            send_item(op, k, idx, w);
            if (i == n_items / 2)
            begin
                drain_results();
            end
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(11'd3, 75, 1'b1);
        run_random_phase(11'd64, 75, 1'b1);
        run_random_phase(11'd1, 60, 1'b1);
        run_random_phase(11'd1023, 75, 1'b1);
        run_random_phase(11'd2047, 80, 1'b0);
        run_random_phase(11'd0, 60, 1'b1);
        run_random_phase(11'd1025, 60, 1'b1);
        run_random_phase(11'd200, 75, 1'b1);
    endtask

    initial
    begin
        foreach (filter_mem[i])
        begin
            filter_mem[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_word_count_edges();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
